/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AST_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define AST_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define AST_ALWAYS(label, clk, rst, expr)
`define AST_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/tms_pkg.sv */
// ----------------------------------------------------------------------------
// tms_pkg
// Types and constants shared by the Turing machine stepper modules.
// ----------------------------------------------------------------------------
package tms_pkg;

   localparam logic [7:0] BLANK_SYMBOL = 8'h5F;

   localparam logic CSR_STEP_LIMIT  = 1'b0;
   localparam logic CSR_START_STATE = 1'b1;

   typedef enum logic [1:0] {
      CMD_INIT = 2'd0,
      CMD_LOAD = 2'd1,
      CMD_RULE = 2'd2,
      CMD_STEP = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_STEPPED     = 4'd0,
      ST_HALTED      = 4'd1,
      ST_LIMIT       = 4'd2,
      ST_RULE_STORED = 4'd3,
      ST_TABLE_FULL  = 4'd4,
      ST_LOADED      = 4'd5,
      ST_INITIALISED = 4'd6,
      ST_OFF_TAPE    = 4'd7,
      ST_TAPE_FULL   = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_RD_HEAD,
      BK_RD_DATA,
      BK_SYM,
      BK_MATCH
   } back_state_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tape_symbol;
      logic [7:0] rule_state;
      logic [7:0] rule_read;
      logic [7:0] rule_write;
      logic [1:0] rule_move;
      logic [7:0] rule_next;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef struct packed {
      logic [23:0] step_limit;
      logic [7:0]  start_state;
   } cfg_type;

endpackage

/* rtl/core/tms_ram.sv */
// ----------------------------------------------------------------------------
// tms_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/tms_front.sv */
// ----------------------------------------------------------------------------
// tms_front
// Accepts commands, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tms_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_command,
   input  logic [7:0]             req_tape_symbol,
   input  logic [7:0]             req_rule_state,
   input  logic [7:0]             req_rule_read,
   input  logic [7:0]             req_rule_write,
   input  logic signed [1:0]      req_rule_move,
   input  logic [7:0]             req_rule_next,
   input  logic                   pop,
   output tms_pkg::queue_out_type q_out
);

   tms_pkg::item_type q_ff [2];
   tms_pkg::item_type item_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   always_comb begin
      item_in.cmd         = tms_pkg::cmd_type'(req_command);
      item_in.tape_symbol = req_tape_symbol;
      item_in.rule_state  = req_rule_state;
      item_in.rule_read   = req_rule_read;
      item_in.rule_write  = req_rule_write;
      item_in.rule_move   = req_rule_move;
      item_in.rule_next   = req_rule_next;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_out.valid = (cnt_ff != 2'd0);
   assign q_out.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

/* rtl/core/tms_back.sv */
// ----------------------------------------------------------------------------
// tms_back
// Executes queued commands against the tape and rule memories.
// ----------------------------------------------------------------------------
module tms_back #(
   parameter int TAPE_CELLS = 1024,
   parameter int RULE_SLOTS = 64,
   parameter int STATE_BITS = 8,
   localparam int HB = $clog2(TAPE_CELLS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tms_pkg::queue_out_type q_out,
   output logic                   pop,
   input  tms_pkg::cfg_type       cfg,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_status,
   output logic [7:0]             rsp_state_now,
   output logic [HB-1:0]          rsp_head_cell,
   output logic [23:0]            rsp_steps_done,
   output logic [7:0]             rsp_symbol_written,
   output logic [HB-1:0]          rsp_lowest_used,
   output logic [HB-1:0]          rsp_highest_used
);

   localparam int RIB = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int CB  = $clog2(RULE_SLOTS + 1);
   localparam int SB  = STATE_BITS;
   localparam int RW  = 2 * SB + 18;
   localparam logic [HB-1:0] CENTRE    = HB'(TAPE_CELLS / 2);
   localparam logic [HB-1:0] LAST_CELL = HB'(TAPE_CELLS - 1);

   tms_pkg::back_state_type state_ff, state_in;
   tms_pkg::status_type     pend_ff, pend_in, fin_status;
   logic [HB-1:0] clr_idx_ff, clr_idx_in;
   logic          clr_reply_ff, clr_reply_in;
   logic [HB-1:0] head_ff, head_in, low_ff, low_in, high_ff, high_in;
   logic [HB:0]   load_pos_ff, load_pos_in;
   logic [SB-1:0] mstate_ff, mstate_in;
   logic [23:0]   steps_ff, steps_in;
   logic [CB-1:0] rcount_ff, rcount_in;
   logic [RIB-1:0] ridx_ff, ridx_in;
   logic [7:0]    sym_ff, sym_in, fin_sym;
   logic          fin;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [3:0]    rsp_status_ff;
   logic [7:0]    rsp_state_ff, rsp_sym_ff;
   logic [HB-1:0] rsp_head_ff, rsp_low_ff, rsp_high_ff;
   logic [23:0]   rsp_steps_ff;

   logic          t_we;
   logic [HB-1:0] t_waddr, t_raddr;
   logic [7:0]    t_wdata, t_rdata;
   logic          r_we;
   logic [RIB-1:0] r_waddr, r_raddr;
   logic [RW-1:0] r_wdata, r_rdata;

   logic [SB-1:0] rule_st, rule_nx;
   logic [7:0]    rule_rd, rule_wr;
   logic [1:0]    rule_mv;
   logic [HB+1:0] tgt;
   logic          off_tape, hit;
   tms_pkg::item_type it;

   tms_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
      .clock(clock), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
      .rd_addr(t_raddr), .rd_data(t_rdata)
   );

   tms_ram #(.WIDTH(RW), .DEPTH(RULE_SLOTS)) u_rules (
      .clock(clock), .wr_en(r_we), .wr_addr(r_waddr), .wr_data(r_wdata),
      .rd_addr(r_raddr), .rd_data(r_rdata)
   );

   assign it      = q_out.item;
   assign rule_nx = r_rdata[SB-1:0];
   assign rule_mv = r_rdata[SB+1:SB];
   assign rule_wr = r_rdata[SB+9:SB+2];
   assign rule_rd = r_rdata[SB+17:SB+10];
   assign rule_st = r_rdata[RW-1:SB+18];
   assign hit     = (rule_st == mstate_ff) && (rule_rd == sym_ff);
   assign tgt     = {2'b00, head_ff} + {{HB{rule_mv[1]}}, rule_mv};
   assign off_tape = (tgt >= (HB+2)'(TAPE_CELLS));

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      clr_idx_in   = clr_idx_ff;
      clr_reply_in = clr_reply_ff;
      head_in      = head_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      load_pos_in  = load_pos_ff;
      mstate_in    = mstate_ff;
      steps_in     = steps_ff;
      rcount_in    = rcount_ff;
      ridx_in      = ridx_ff;
      sym_in       = sym_ff;
      pop          = 1'b0;
      fin          = 1'b0;
      fin_status   = pend_ff;
      fin_sym      = sym_ff;
      t_we         = 1'b0;
      t_waddr      = head_ff;
      t_wdata      = tms_pkg::BLANK_SYMBOL;
      t_raddr      = head_ff;
      r_we         = 1'b0;
      r_waddr      = RIB'(rcount_ff);
      r_wdata      = {SB'(it.rule_state), it.rule_read, it.rule_write,
                      it.rule_move, SB'(it.rule_next)};
      r_raddr      = ridx_ff;

      case (state_ff)
         tms_pkg::BK_CLEAR: begin
            t_we       = 1'b1;
            t_waddr    = clr_idx_ff;
            clr_idx_in = clr_idx_ff + HB'(1);
            if (clr_idx_ff == LAST_CELL) begin
               state_in = clr_reply_ff ? tms_pkg::BK_RD_HEAD : tms_pkg::BK_IDLE;
            end
         end
         tms_pkg::BK_IDLE: begin
            if (q_out.valid && (!rsp_valid_ff || !rsp_stall)) begin
               pop = 1'b1;
               case (it.cmd)
                  tms_pkg::CMD_INIT: begin
                     head_in      = CENTRE;
                     low_in       = CENTRE;
                     high_in      = CENTRE;
                     load_pos_in  = {1'b0, CENTRE};
                     mstate_in    = SB'(cfg.start_state);
                     steps_in     = '0;
                     rcount_in    = '0;
                     clr_idx_in   = '0;
                     clr_reply_in = 1'b1;
                     pend_in      = tms_pkg::ST_INITIALISED;
                     state_in     = tms_pkg::BK_CLEAR;
                  end
                  tms_pkg::CMD_LOAD: begin
                     if (load_pos_ff >= (HB+1)'(TAPE_CELLS)) begin
                        pend_in = tms_pkg::ST_TAPE_FULL;
                     end else begin
                        t_we        = 1'b1;
                        t_waddr     = load_pos_ff[HB-1:0];
                        t_wdata     = it.tape_symbol;
                        load_pos_in = load_pos_ff + (HB+1)'(1);
                        if (load_pos_ff[HB-1:0] > high_ff) begin
                           high_in = load_pos_ff[HB-1:0];
                        end
                        pend_in = tms_pkg::ST_LOADED;
                     end
                     state_in = tms_pkg::BK_RD_HEAD;
                  end
                  tms_pkg::CMD_RULE: begin
                     if (rcount_ff == CB'(RULE_SLOTS)) begin
                        pend_in = tms_pkg::ST_TABLE_FULL;
                     end else begin
                        r_we      = 1'b1;
                        rcount_in = rcount_ff + CB'(1);
                        pend_in   = tms_pkg::ST_RULE_STORED;
                     end
                     state_in = tms_pkg::BK_RD_DATA;
                  end
                  tms_pkg::CMD_STEP: begin
                     state_in = tms_pkg::BK_SYM;
                  end
                  default: begin
                     state_in = tms_pkg::BK_IDLE;
                  end
               endcase
            end
         end
         tms_pkg::BK_RD_HEAD: begin
            state_in = tms_pkg::BK_RD_DATA;
         end
         tms_pkg::BK_RD_DATA: begin
            fin      = 1'b1;
            fin_sym  = t_rdata;
            state_in = tms_pkg::BK_IDLE;
         end
         tms_pkg::BK_SYM: begin
            sym_in  = t_rdata;
            fin_sym = t_rdata;
            r_raddr = '0;
            ridx_in = '0;
            if (steps_ff >= cfg.step_limit) begin
               fin        = 1'b1;
               fin_status = tms_pkg::ST_LIMIT;
               state_in   = tms_pkg::BK_IDLE;
            end else if (rcount_ff == '0) begin
               fin        = 1'b1;
               fin_status = tms_pkg::ST_HALTED;
               state_in   = tms_pkg::BK_IDLE;
            end else begin
               state_in = tms_pkg::BK_MATCH;
            end
         end
         tms_pkg::BK_MATCH: begin
            if (hit) begin
               fin      = 1'b1;
               state_in = tms_pkg::BK_IDLE;
               if (off_tape) begin
                  fin_status = tms_pkg::ST_OFF_TAPE;
               end else begin
                  t_we       = 1'b1;
                  t_wdata    = rule_wr;
                  head_in    = tgt[HB-1:0];
                  mstate_in  = rule_nx;
                  steps_in   = steps_ff + 24'd1;
                  if (tgt[HB-1:0] < low_ff) begin
                     low_in = tgt[HB-1:0];
                  end
                  if (tgt[HB-1:0] > high_ff) begin
                     high_in = tgt[HB-1:0];
                  end
                  fin_status = tms_pkg::ST_STEPPED;
                  fin_sym    = rule_wr;
               end
            end else if (CB'(ridx_ff) + CB'(1) == rcount_ff) begin
               fin        = 1'b1;
               fin_status = tms_pkg::ST_HALTED;
               state_in   = tms_pkg::BK_IDLE;
            end else begin
               ridx_in = ridx_ff + RIB'(1);
               r_raddr = ridx_ff + RIB'(1);
            end
         end
         default: begin
            state_in = tms_pkg::BK_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && rsp_stall) || fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tms_pkg::BK_CLEAR;
         pend_ff      <= tms_pkg::ST_INITIALISED;
         clr_idx_ff   <= '0;
         clr_reply_ff <= 1'b0;
         head_ff      <= CENTRE;
         low_ff       <= CENTRE;
         high_ff      <= CENTRE;
         load_pos_ff  <= {1'b0, CENTRE};
         mstate_ff    <= '0;
         steps_ff     <= '0;
         rcount_ff    <= '0;
         ridx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         clr_idx_ff   <= clr_idx_in;
         clr_reply_ff <= clr_reply_in;
         head_ff      <= head_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         load_pos_ff  <= load_pos_in;
         mstate_ff    <= mstate_in;
         steps_ff     <= steps_in;
         rcount_ff    <= rcount_in;
         ridx_ff      <= ridx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
      if (fin) begin
         rsp_status_ff <= fin_status;
         rsp_state_ff  <= 8'(mstate_in);
         rsp_head_ff   <= head_in;
         rsp_steps_ff  <= steps_in;
         rsp_sym_ff    <= fin_sym;
         rsp_low_ff    <= low_in;
         rsp_high_ff   <= high_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_state_now      = rsp_state_ff;
   assign rsp_head_cell      = rsp_head_ff;
   assign rsp_steps_done     = rsp_steps_ff;
   assign rsp_symbol_written = rsp_sym_ff;
   assign rsp_lowest_used    = rsp_low_ff;
   assign rsp_highest_used   = rsp_high_ff;

endmodule

/* rtl/core/turing_machine_stepper.sv */
// ----------------------------------------------------------------------------
// turing_machine_stepper
// Single-tape Turing machine with command queue and one result per command.
// ----------------------------------------------------------------------------
// One result transfer follows every command transfer, in order. Commands land
// in a two-entry queue, so the request side keeps moving while a result waits
// to be taken. The executor handles one command at a time: add-rule passes
// through RD_DATA, load through RD_HEAD and RD_DATA; a step reads the symbol
// under the head and then examines the rules one at a time, in insertion
// order, through the rule memory read port, up to the matching rule or, on a
// halt, through every stored rule. Init rewrites every tape cell to blank, one
// cell a cycle through the tape memory write port. After reset the same
// clearing pass runs before the first command is executed; configuration
// writes are taken throughout.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module turing_machine_stepper #(
   parameter int TAPE_CELLS = 1024,
   parameter int RULE_SLOTS = 64,
   parameter int STATE_BITS = 8,
   localparam int HB = $clog2(TAPE_CELLS)
) (
   input  logic              clock,
   input  logic              reset,
   // command channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_command,
   input  logic [7:0]        req_tape_symbol,
   input  logic [7:0]        req_rule_state,
   input  logic [7:0]        req_rule_read,
   input  logic [7:0]        req_rule_write,
   input  logic signed [1:0] req_rule_move,
   input  logic [7:0]        req_rule_next,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_status,
   output logic [7:0]        rsp_state_now,
   output logic [HB-1:0]     rsp_head_cell,
   output logic [23:0]       rsp_steps_done,
   output logic [7:0]        rsp_symbol_written,
   output logic [HB-1:0]     rsp_lowest_used,
   output logic [HB-1:0]     rsp_highest_used,
   // register writes
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [23:0]       csr_wdata
);

   tms_pkg::cfg_type       cfg_ff, cfg_in;
   tms_pkg::queue_out_type q_out;
   logic                   pop;

   // Update the register selected by the index, hold the other.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            tms_pkg::CSR_STEP_LIMIT:  cfg_in.step_limit  = csr_wdata;
            tms_pkg::CSR_START_STATE: cfg_in.start_state = csr_wdata[7:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_limit  <= 24'd10000;
         cfg_ff.start_state <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accept, decode and queue commands.
   tms_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_tape_symbol(req_tape_symbol),
      .req_rule_state(req_rule_state), .req_rule_read(req_rule_read),
      .req_rule_write(req_rule_write), .req_rule_move(req_rule_move),
      .req_rule_next(req_rule_next),
      .pop(pop), .q_out(q_out)
   );

   // Back end: run each command against the tape and rules, drive results.
   tms_back #(
      .TAPE_CELLS(TAPE_CELLS), .RULE_SLOTS(RULE_SLOTS), .STATE_BITS(STATE_BITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .q_out(q_out), .pop(pop), .cfg(cfg_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_state_now(rsp_state_now),
      .rsp_head_cell(rsp_head_cell), .rsp_steps_done(rsp_steps_done),
      .rsp_symbol_written(rsp_symbol_written),
      .rsp_lowest_used(rsp_lowest_used), .rsp_highest_used(rsp_highest_used)
   );

   // The head always lies within the used bounds.
   `AST_IMPLIES(a_head_in_bounds, clock, reset, rsp_valid, (rsp_lowest_used <= rsp_head_cell) && (rsp_head_cell <= rsp_highest_used))
   // A successful step has always been counted.
   `AST_IMPLIES(a_step_counted, clock, reset, rsp_valid && (rsp_status == tms_pkg::ST_STEPPED), rsp_steps_done != 24'd0)
   // Init leaves a fresh machine behind.
   `AST_IMPLIES(a_init_fresh, clock, reset, rsp_valid && (rsp_status == tms_pkg::ST_INITIALISED), (rsp_steps_done == 24'd0) && (rsp_lowest_used == rsp_highest_used))

endmodule

/* test/tms_checker.sv */
// ----------------------------------------------------------------------------
// tms_checker
// Watches the command and result channels of the Turing machine stepper,
// runs its own machine model on every command transfer and compares each
// result transfer with the oldest predicted result.
// ----------------------------------------------------------------------------
module tms_checker
   import tms_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_command,
   input  logic [7:0]        req_tape_symbol,
   input  logic [7:0]        req_rule_state,
   input  logic [7:0]        req_rule_read,
   input  logic [7:0]        req_rule_write,
   input  logic [1:0]        req_rule_move,
   input  logic [7:0]        req_rule_next,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [3:0]        rsp_status,
   input  logic [7:0]        rsp_state_now,
   input  logic [9:0]        rsp_head_cell,
   input  logic [23:0]       rsp_steps_done,
   input  logic [7:0]        rsp_symbol_written,
   input  logic [9:0]        rsp_lowest_used,
   input  logic [9:0]        rsp_highest_used,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [23:0]       csr_wdata,
   output int                fail_count,
   output int                pending_count
);

   localparam int CELLS = 1024;
   localparam int SLOTS = 64;

   typedef struct packed {
      logic [3:0]  status;
      logic [7:0]  state_now;
      logic [9:0]  head;
      logic [23:0] steps;
      logic [7:0]  written;
      logic [9:0]  low;
      logic [9:0]  high;
   } outcome_type;

   typedef struct packed {
      logic [7:0] st;
      logic [7:0] rd;
      logic [7:0] wr;
      logic [1:0] mv;
      logic [7:0] nx;
   } rule_type;

   logic [7:0]  tape [CELLS];
   rule_type    rules [SLOTS];
   int          n_rules, n_loaded;
   logic [9:0]  head, low, high;
   logic [7:0]  mstate;
   logic [23:0] steps, limit;
   logic [7:0]  start;
   outcome_type expected_q [$];

   function automatic void blank_machine();
      foreach (tape[i]) tape[i] = BLANK_SYMBOL;
      head = 10'(CELLS / 2);
      low = 10'(CELLS / 2);
      high = 10'(CELLS / 2);
      mstate = start;
      steps = '0;
      n_rules = 0;
      n_loaded = 0;
   endfunction

   // Run one step; returns the status and the symbol written on success.
   function automatic status_type run_step(output logic [7:0] wsym);
      int hit, target, mv;
      rule_type r;
      hit = -1;
      wsym = '0;
      if (steps >= limit) return ST_LIMIT;
      for (int i = 0; i < n_rules; i++)
         if (rules[i[5:0]].st == mstate && rules[i[5:0]].rd == tape[head]) begin
            hit = i;
            break;
         end
      if (hit < 0) return ST_HALTED;
      r = rules[hit[5:0]];
      mv = $signed(r.mv);
      target = int'(head) + mv;
      if (target < 0 || target >= CELLS) return ST_OFF_TAPE;
      tape[head] = r.wr;
      wsym = r.wr;
      mstate = r.nx;
      head = target[9:0];
      if (head < low) low = head;
      if (head > high) high = head;
      steps++;
      return ST_STEPPED;
   endfunction

   function automatic outcome_type predict_outcome(cmd_type cmd, logic [7:0] sym,
         rule_type r);
      outcome_type o;
      logic [7:0] wsym;
      logic wrote;
      int pos;
      wrote = 1'b0;
      case (cmd)
         CMD_INIT: begin
            blank_machine();
            o.status = ST_INITIALISED;
         end
         CMD_LOAD: begin
            pos = CELLS / 2 + n_loaded;
            if (pos >= CELLS) o.status = ST_TAPE_FULL;
            else begin
               tape[pos[9:0]] = sym;
               n_loaded++;
               if (pos[9:0] > high) high = pos[9:0];
               o.status = ST_LOADED;
            end
         end
         CMD_RULE: begin
            if (n_rules >= SLOTS) o.status = ST_TABLE_FULL;
            else begin
               rules[n_rules[5:0]] = r;
               n_rules++;
               o.status = ST_RULE_STORED;
            end
         end
         default: begin
            o.status = run_step(wsym);
            wrote = (o.status == ST_STEPPED);
         end
      endcase
      o.state_now = mstate;
      o.head = head;
      o.steps = steps;
      o.written = wrote ? wsym : tape[head];
      o.low = low;
      o.high = high;
      return o;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         limit = 24'd10000;
         start = '0;
         blank_machine();
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_STEP_LIMIT) limit = csr_wdata;
            else start = csr_wdata[7:0];
         end
         // compare the result transfer before modelling this edge's command
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_status != e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  fail_count++;
               end
               if (rsp_state_now != e.state_now) begin
                  $error("state_now: expected %0d, got %0d", e.state_now, rsp_state_now);
                  fail_count++;
               end
               if (rsp_head_cell != e.head) begin
                  $error("head_cell: expected %0d, got %0d", e.head,
                     rsp_head_cell);
                  fail_count++;
               end
               if (rsp_steps_done != e.steps) begin
                  $error("steps_done: expected %0d, got %0d", e.steps, rsp_steps_done);
                  fail_count++;
               end
               if (rsp_symbol_written != e.written) begin
                  $error("symbol_written: expected %0d, got %0d", e.written,
                     rsp_symbol_written);
                  fail_count++;
               end
               if (rsp_lowest_used != e.low) begin
                  $error("lowest_used: expected %0d, got %0d", e.low, rsp_lowest_used);
                  fail_count++;
               end
               if (rsp_highest_used != e.high) begin
                  $error("highest_used: expected %0d, got %0d", e.high,
                     rsp_highest_used);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(predict_outcome(cmd_type'(req_command), req_tape_symbol,
               '{req_rule_state, req_rule_read, req_rule_write, req_rule_move,
                 req_rule_next}));
      end
   end

endmodule

/* test/tb_turing_machine_stepper.sv */
// ----------------------------------------------------------------------------
// tb_turing_machine_stepper
// Drives commands, register writes and result stalls into the Turing machine
// stepper; a checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_turing_machine_stepper;
   import tms_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_command = CMD_INIT;
   logic [7:0]        req_tape_symbol = '0;
   logic [7:0]        req_rule_state = '0;
   logic [7:0]        req_rule_read = '0;
   logic [7:0]        req_rule_write = '0;
   logic signed [1:0] req_rule_move = '0;
   logic [7:0]        req_rule_next = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [3:0]        rsp_status;
   logic [7:0]        rsp_state_now;
   logic [9:0]        rsp_head_cell;
   logic [23:0]       rsp_steps_done;
   logic [7:0]        rsp_symbol_written;
   logic [9:0]        rsp_lowest_used;
   logic [9:0]        rsp_highest_used;
   logic              csr_we = 1'b0;
   logic [0:0]        csr_index = CSR_STEP_LIMIT;
   logic [23:0]       csr_wdata = '0;
   int                fail_count;
   int                pending_count;

   // idle percentages of the two sides, changed between phases
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   turing_machine_stepper dut (.*);

   tms_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // random result stalls, changed at the falling edge
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // Transfer one command: hold the payload steady until it is taken. Valid
   // stays high afterwards so that commands can follow back to back; idle
   // cycles and drains drop it.
   task automatic send_command(cmd_type cmd, logic [7:0] sym, logic [7:0] st,
         logic [7:0] rd, logic [7:0] wr, logic [1:0] mv, logic [7:0] nx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_tape_symbol <= sym;
      req_rule_state <= st;
      req_rule_read <= rd;
      req_rule_write <= wr;
      req_rule_move <= mv;
      req_rule_next <= nx;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_simple(cmd_type cmd);
      send_command(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
         2'($urandom), 8'($urandom));
   endtask

   // Drain every result, then allow for a pass that yields no result yet
   // (an init clears the whole tape).
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (1100) @(negedge clock);
   endtask

   task automatic write_register(logic [0:0] idx, logic [23:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // blank now and then, else the base or one of the two symbols above it
   function automatic logic [7:0] pick_symbol(logic [7:0] base);
      return ($urandom_range(3) == 0) ? BLANK_SYMBOL : base + 8'($urandom_range(2));
   endfunction

   // Build a small random program over a few states and symbols, load a
   // short tape and run it for a batch of steps, now and then another command.
   task automatic run_program(int n_steps, output int n_sent);
      int n_rules, n_load;
      logic [7:0] base;
      base = 8'($urandom);
      n_rules = $urandom_range(1, 12);
      n_load = $urandom_range(0, 6);
      send_simple(CMD_INIT);
      for (int i = 0; i < n_load; i++)
         send_command(CMD_LOAD, base + 8'($urandom_range(2)), 8'd0, 8'd0, 8'd0,
            2'd0, 8'd0);
      for (int i = 0; i < n_rules; i++)
         send_command(CMD_RULE, 8'd0, 8'($urandom_range(3)), pick_symbol(base),
            pick_symbol(base), 2'($urandom), 8'($urandom_range(3)));
      for (int i = 0; i < n_steps; i++) begin
         if ($urandom_range(19) == 0) send_simple(cmd_type'(2'($urandom_range(3))));
         else send_simple(CMD_STEP);
      end
      n_sent = 1 + n_load + n_rules + n_steps;
   endtask

   task automatic random_phase(int n_items);
      int sent;
      sent = 0;
      while (sent < n_items) begin
         int n;
         int k;
         n = $urandom_range(8, 30);
         run_program(n, k);
         sent += k;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: register defaults, start state at its top, then edges.
      write_register(CSR_START_STATE, 24'hFF);
      send_simple(CMD_INIT);
      send_command(CMD_LOAD, 8'h00, 8'd0, 8'd0, 8'd0, 2'd0, 8'd0);
      send_command(CMD_LOAD, 8'hFF, 8'd0, 8'd0, 8'd0, 2'd0, 8'd0);
      // halt with no rules
      send_simple(CMD_STEP);
      // rules: stay, right, left, move code two, with extreme fields
      send_command(CMD_RULE, 8'd0, 8'hFF, 8'h00, 8'hAA, 2'b00, 8'h01);
      send_command(CMD_RULE, 8'd0, 8'h01, 8'hFF, 8'h55, 2'b01, 8'h02);
      send_command(CMD_RULE, 8'd0, 8'h02, BLANK_SYMBOL, 8'hFF, 2'b11, 8'h03);
      send_command(CMD_RULE, 8'd0, 8'h03, 8'hFF, 8'h00, 2'b10, 8'h00);
      send_command(CMD_RULE, 8'd0, 8'h00, 8'hAA, 8'h11, 2'b10, 8'hFF);
      repeat (6) send_simple(CMD_STEP);
      drain_results();

      // step limit zero, then one
      write_register(CSR_STEP_LIMIT, 24'd0);
      write_register(CSR_START_STATE, 24'h00);
      send_simple(CMD_INIT);
      send_command(CMD_RULE, 8'd0, 8'h00, BLANK_SYMBOL, 8'h41, 2'b11, 8'h00);
      send_simple(CMD_STEP);
      drain_results();
      write_register(CSR_STEP_LIMIT, 24'd1);
      send_simple(CMD_STEP);
      send_simple(CMD_STEP);
      drain_results();

      // Walk the head two cells at a time to the left edge and beyond.
      write_register(CSR_STEP_LIMIT, 24'hFFFFFF);
      send_simple(CMD_INIT);
      send_command(CMD_RULE, 8'd0, 8'h00, BLANK_SYMBOL, BLANK_SYMBOL, 2'b10, 8'h00);
      repeat (258) send_simple(CMD_STEP);
      drain_results();
      // fill the upper half of the tape and overflow the loads and the table
      send_simple(CMD_INIT);
      send_command(CMD_RULE, 8'd0, 8'h00, 8'h07, 8'h07, 2'b01, 8'h00);
      repeat (513) send_command(CMD_LOAD, 8'h07, 8'd0, 8'd0, 8'd0, 2'd0, 8'd0);
      repeat (4) send_simple(CMD_STEP);
      repeat (64) send_simple(CMD_RULE);
      drain_results();

      // Random phases with varied idling and register settings.
      write_register(CSR_STEP_LIMIT, 24'd10000);
      write_register(CSR_START_STATE, 24'($urandom_range(3)));
      send_idle_pct = 17;
      recv_idle_pct = 88;
      random_phase(25);
      drain_results();

      write_register(CSR_STEP_LIMIT, 24'($urandom_range(5, 20)));
      write_register(CSR_START_STATE, 24'($urandom_range(3)));
      send_idle_pct = 88;
      recv_idle_pct = 17;
      random_phase(25);
      drain_results();

      write_register(CSR_STEP_LIMIT, 24'hFFFFFF);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(25);
      drain_results();

      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #30000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
